>>> hdl/stif_pkg.sv
package stif_pkg;

	localparam int CAPACITY  = 256;
	localparam int KEY_BITS  = 32;
	localparam int ADDR_BITS = $clog2(CAPACITY);
	localparam int CNT_BITS  = ADDR_BITS + 1;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_FIND   = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO_KEY  = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_BAD_INDEX = 3'd4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] key;
		logic [7:0]  index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  found_index;
		logic [31:0] value_out;
		logic [8:0]  entry_count;
	} out_item_t;

	typedef struct packed {
		logic                 rd_en;
		logic [ADDR_BITS-1:0] rd_addr;
		logic                 wr_en;
		logic [ADDR_BITS-1:0] wr_addr;
		logic [KEY_BITS-1:0]  wr_data;
	} mem_req_t;

endpackage

>>> hdl/stif_mem.sv
module stif_mem (
	input  logic                                clk,
	input  stif_pkg::mem_req_t                  mreq,
	output logic [stif_pkg::KEY_BITS-1:0]       rd_data
);
	import stif_pkg::*;

	logic [KEY_BITS-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[mreq.wr_addr] <= mreq.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.rd_en) begin
			rd_data <= mem[mreq.rd_addr];
		end
	end

endmodule

>>> hdl/stif_ctrl.sv
module stif_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  stif_pkg::in_item_t              req,
	input  logic                            sorted_mode,
	input  logic [stif_pkg::KEY_BITS-1:0]   rd_data,
	output stif_pkg::mem_req_t              mreq,
	output logic                            busy,
	output logic                            done,
	output stif_pkg::out_item_t             result
);
	import stif_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_EV    = 3'd2;
	localparam logic [2:0] S_MID   = 3'd3;
	localparam logic [2:0] S_WRKEY = 3'd4;

	localparam logic [2:0] PH_TAIL_I = 3'd0;
	localparam logic [2:0] PH_HEAD_I = 3'd1;
	localparam logic [2:0] PH_MID    = 3'd2;
	localparam logic [2:0] PH_HEAD_F = 3'd3;
	localparam logic [2:0] PH_TAIL_F = 3'd4;
	localparam logic [2:0] PH_SCAN   = 3'd5;
	localparam logic [2:0] PH_FETCH  = 3'd6;
	localparam logic [2:0] PH_SHIFT  = 3'd7;

	logic [2:0]           state_q, phase_q;
	logic [1:0]           req_q;
	logic [KEY_BITS-1:0]  key_q, val_q;
	logic [ADDR_BITS-1:0] idx_q, addr_q, pos_q, lo_q, hi_q;
	logic [CNT_BITS-1:0]  fill_q;
	logic                 done_q;
	out_item_t            res_q;

	logic                 lt, eq;
	logic [ADDR_BITS:0]   mid_sum;
	logic [ADDR_BITS-1:0] mid;
	logic [ADDR_BITS-1:0] last;

	assign lt      = key_q < rd_data;
	assign eq      = key_q == rd_data;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[ADDR_BITS:1];
	assign last    = fill_q[ADDR_BITS-1:0] - 1'b1;

	function automatic out_item_t mk_res(logic [2:0] st, logic [ADDR_BITS-1:0] fi,
		logic [KEY_BITS-1:0] v, logic [CNT_BITS-1:0] cnt);
		out_item_t r;
		r.status      = st;
		r.found_index = 8'(fi);
		r.value_out   = 32'(v);
		r.entry_count = 9'(cnt);
		return r;
	endfunction

	// memory port: reads at addr_q, shift writes move the word one slot
	always_comb begin
		mreq.rd_en   = state_q == S_RD;
		mreq.rd_addr = addr_q;
		mreq.wr_en   = 1'b0;
		mreq.wr_addr = pos_q;
		mreq.wr_data = key_q;
		if (state_q == S_EV && phase_q == PH_SHIFT) begin
			mreq.wr_en   = 1'b1;
			mreq.wr_addr = (req_q == REQ_INSERT) ? addr_q + 1'b1 : addr_q - 1'b1;
			mreq.wr_data = rd_data;
		end else if (state_q == S_WRKEY) begin
			mreq.wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q <= req.key;
						req_q <= req.req_type;
						idx_q <= req.index;
						case (req.req_type)
							REQ_INSERT: begin
								if (req.key == '0) begin
									done_q <= 1'b1;
									res_q  <= mk_res(ST_ZERO_KEY, '0, '0, fill_q);
								end else if (fill_q == CNT_BITS'(CAPACITY)) begin
									done_q <= 1'b1;
									res_q  <= mk_res(ST_FULL, '0, '0, fill_q);
								end else if (sorted_mode && fill_q != '0) begin
									addr_q  <= last;
									phase_q <= PH_TAIL_I;
									state_q <= S_RD;
								end else begin
									pos_q   <= fill_q[ADDR_BITS-1:0];
									state_q <= S_WRKEY;
								end
							end
							REQ_FIND: begin
								if (fill_q == '0) begin
									done_q <= 1'b1;
									res_q  <= mk_res(ST_NOT_FOUND, '0, '0, fill_q);
								end else begin
									addr_q  <= '0;
									phase_q <= sorted_mode ? PH_HEAD_F : PH_SCAN;
									state_q <= S_RD;
								end
							end
							default: begin
								if ({1'b0, req.index} >= fill_q) begin
									done_q <= 1'b1;
									res_q  <= mk_res(ST_BAD_INDEX, req.index, '0, fill_q);
								end else begin
									addr_q  <= req.index;
									phase_q <= PH_FETCH;
									state_q <= S_RD;
								end
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_MID: begin
					if (mid == lo_q) begin
						if (req_q == REQ_INSERT) begin
							pos_q   <= mid + 1'b1;
							addr_q  <= last;
							phase_q <= PH_SHIFT;
							state_q <= S_RD;
						end else begin
							done_q  <= 1'b1;
							res_q   <= mk_res(ST_NOT_FOUND, '0, '0, fill_q);
							state_q <= S_IDLE;
						end
					end else begin
						addr_q  <= mid;
						phase_q <= PH_MID;
						state_q <= S_RD;
					end
				end
				S_WRKEY: begin
					fill_q  <= fill_q + 1'b1;
					done_q  <= 1'b1;
					res_q   <= mk_res(ST_OK, pos_q, key_q, fill_q + 1'b1);
					state_q <= S_IDLE;
				end
				S_EV: begin
					state_q <= S_IDLE;
					case (phase_q)
						PH_TAIL_I: begin
							if (!lt) begin
								pos_q   <= fill_q[ADDR_BITS-1:0];
								state_q <= S_WRKEY;
							end else begin
								addr_q  <= '0;
								phase_q <= PH_HEAD_I;
								state_q <= S_RD;
							end
						end
						PH_HEAD_I: begin
							if (lt || eq) begin
								pos_q   <= '0;
								addr_q  <= last;
								phase_q <= PH_SHIFT;
								state_q <= S_RD;
							end else begin
								lo_q    <= '0;
								hi_q    <= last;
								state_q <= S_MID;
							end
						end
						PH_MID: begin
							if (eq) begin
								if (req_q == REQ_INSERT) begin
									pos_q   <= addr_q;
									addr_q  <= last;
									phase_q <= PH_SHIFT;
									state_q <= S_RD;
								end else begin
									done_q <= 1'b1;
									res_q  <= mk_res(ST_OK, addr_q, key_q, fill_q);
								end
							end else begin
								if (lt) begin
									hi_q <= addr_q;
								end else begin
									lo_q <= addr_q;
								end
								state_q <= S_MID;
							end
						end
						PH_HEAD_F: begin
							if (eq) begin
								done_q <= 1'b1;
								res_q  <= mk_res(ST_OK, '0, key_q, fill_q);
							end else if (lt || fill_q == CNT_BITS'(1)) begin
								done_q <= 1'b1;
								res_q  <= mk_res(ST_NOT_FOUND, '0, '0, fill_q);
							end else begin
								addr_q  <= last;
								phase_q <= PH_TAIL_F;
								state_q <= S_RD;
							end
						end
						PH_TAIL_F: begin
							if (eq) begin
								done_q <= 1'b1;
								res_q  <= mk_res(ST_OK, addr_q, key_q, fill_q);
							end else if (!lt) begin
								done_q <= 1'b1;
								res_q  <= mk_res(ST_NOT_FOUND, '0, '0, fill_q);
							end else begin
								lo_q    <= '0;
								hi_q    <= last;
								state_q <= S_MID;
							end
						end
						PH_SCAN: begin
							if (eq) begin
								done_q <= 1'b1;
								res_q  <= mk_res(ST_OK, addr_q, key_q, fill_q);
							end else if ({1'b0, addr_q} + 1'b1 == fill_q) begin
								done_q <= 1'b1;
								res_q  <= mk_res(ST_NOT_FOUND, '0, '0, fill_q);
							end else begin
								addr_q  <= addr_q + 1'b1;
								state_q <= S_RD;
							end
						end
						PH_FETCH: begin
							val_q <= rd_data;
							if (req_q == REQ_READ) begin
								done_q <= 1'b1;
								res_q  <= mk_res(ST_OK, idx_q, rd_data, fill_q);
							end else if ({1'b0, idx_q} + 1'b1 < fill_q) begin
								addr_q  <= idx_q + 1'b1;
								phase_q <= PH_SHIFT;
								state_q <= S_RD;
							end else begin
								fill_q <= fill_q - 1'b1;
								done_q <= 1'b1;
								res_q  <= mk_res(ST_OK, idx_q, rd_data, fill_q - 1'b1);
							end
						end
						default: begin
							// shift step, the write goes out this cycle
							if (req_q == REQ_INSERT) begin
								if (addr_q == pos_q) begin
									state_q <= S_WRKEY;
								end else begin
									addr_q  <= addr_q - 1'b1;
									state_q <= S_RD;
								end
							end else if ({1'b0, addr_q} + 1'b1 < fill_q) begin
								addr_q  <= addr_q + 1'b1;
								state_q <= S_RD;
							end else begin
								fill_q <= fill_q - 1'b1;
								done_q <= 1'b1;
								res_q  <= mk_res(ST_OK, idx_q, val_q, fill_q - 1'b1);
							end
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

endmodule

>>> hdl/sorted_table_insert_find_core.sv
// sorted key table with insert, find, remove at index and read at index.
// a request is taken when start is high and busy is low; its single result
// appears on result with done high for exactly one cycle, and the receiver
// cannot stall it. busy falls in the same cycle done rises, so the next
// request may follow at once. all keys live in one memory with one read
// port and one write port (one read, one write per cycle, registered read
// data), and each memory access of a request is a read state followed by
// an evaluate state, so the time a request takes grows with its reads:
//   zero key, full table, bad index, find on empty table: no memory read
//   read at index: one read of the entry
//   unsorted insert: key written at the tail; sorted insert: key written
//     at the tail when not below it, otherwise tail and head checks, a
//     binary search (one read per probe) unless the key goes at the head,
//     then one read per entry shifted up and a final write of the key
//   sorted find: head and tail checks, then binary search; unsorted find:
//     one read per entry scanned
//   remove: one read of the entry plus one read per entry shifted down
// sorted_mode is written through cfg_valid/cfg_ready while the block is idle
module sorted_table_insert_find_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  stif_pkg::in_item_t     req,
	output logic                   done,
	output stif_pkg::out_item_t    result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data
);
	import stif_pkg::*;

	logic                sorted_mode_q;
	mem_req_t            mreq;
	logic [KEY_BITS-1:0] rd_data;

	// config transaction only taken while no request is in flight
	assign cfg_ready = ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			sorted_mode_q <= cfg_data;
		end
	end

	// sequencer: tail/head checks, binary search, scan, index fetch and shifts
	stif_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req         (req),
		.sorted_mode (sorted_mode_q),
		.rd_data     (rd_data),
		.mreq        (mreq),
		.busy        (busy),
		.done        (done),
		.result      (result)
	);

	// key storage
	stif_mem u_mem (
		.clk     (clk),
		.mreq    (mreq),
		.rd_data (rd_data)
	);

endmodule

>>> hdl/stif_checker.sv
module stif_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input stif_pkg::out_item_t result
);
	import stif_pkg::*;

	// every accepted request either answers at once or occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done) else $error("accept without busy or result");

	// end of a request always comes with its result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("request ended without result");

	// result shows only when idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status <= ST_BAD_INDEX &&
			result.entry_count <= 9'(CAPACITY)))
		else $error("bad status or count");

endmodule

bind sorted_table_insert_find_core stif_checker u_stif_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
